>>> rtl/keyed_record_table_defines.svh
// Assertion macros shared by the keyed record table checkers.
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define KRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define KRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/krt_pkg.sv
// Types and codes shared by the keyed record table modules.
`timescale 1ns / 1ps

package krt_pkg;

  // Operation codes carried by the kind field.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam int PosW   = 4;
  localparam int CountW = 5;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] origin;
    logic [15:0] destination;
    logic [31:0] weight;
  } krt_rec_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } krt_mem_ctl_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] entry_count;
  } krt_result_t;

endpackage

>>> rtl/keyed_record_table.sv
// Top level of the keyed record table: sequencer, record memory, result register.
`timescale 1ns / 1ps

//  Channel   Ports                                                   Direction
//  input     in_valid, in_stall, in_kind, in_key, in_new_key,        into block
//            in_origin, in_destination, in_weight_bits
//  result    out_valid, out_stall, out_status, out_position,         out of block
//            out_entry_count
//
//  One item is worked on at a time. Lookup, update and insert search the record memory
//  from entry 0 upward until a match or the last of the N records held, reading one
//  entry per cycle through its single read port. A remove that finds its id then shifts
//  each record above the removed position P down by one, reading and writing it back once.
//  Reset clears the record count; the memory contents are not cleared and need no
//  clearing pass, as only entries below the count are ever read.
//  A stalled result waits in the output register while the next item is accepted.

module keyed_record_table import krt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic signed [31:0]  in_key,
  input  logic signed [31:0]  in_new_key,
  input  logic [15:0]         in_origin,
  input  logic [15:0]         in_destination,
  input  logic [31:0]         in_weight_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [PosW-1:0]     out_position,
  output logic [CountW-1:0]   out_entry_count
);

  // Index width addresses every entry; count width also holds CAPACITY itself.
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  krt_mem_ctl_t  mem_ctl;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  krt_rec_t      wr_data;
  krt_rec_t      rd_data;
  logic          res_valid;
  logic          res_ready;
  krt_result_t   res;

  logic          out_valid_r, out_valid_nxt;
  krt_result_t   out_res_r;

  krt_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_key         ($unsigned(in_key)),
    .in_new_key     ($unsigned(in_new_key)),
    .in_origin      (in_origin),
    .in_destination (in_destination),
    .in_weight_bits (in_weight_bits),
    .mem_ctl        (mem_ctl),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_data        (rd_data),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready)
  );

  krt_store #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // The output register takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_position    = out_res_r.position;
  assign out_entry_count = out_res_r.entry_count;

endmodule

>>> rtl/krt_store.sv
// Record memory: one write port and one registered read port.
`timescale 1ns / 1ps

module krt_store import krt_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic         clk,
  input  krt_mem_ctl_t mem_ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  krt_rec_t     wr_data,
  output krt_rec_t     rd_data
);

  krt_rec_t mem [DEPTH];
  krt_rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/krt_ctrl.sv
// Sequencer: searches the memory, applies the operation and shifts on remove.
`timescale 1ns / 1ps

module krt_ctrl import krt_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int IW       = 4,
  parameter int CW       = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_kind,
  input  logic [31:0]   in_key,
  input  logic [31:0]   in_new_key,
  input  logic [15:0]   in_origin,
  input  logic [15:0]   in_destination,
  input  logic [31:0]   in_weight_bits,
  output krt_mem_ctl_t  mem_ctl,
  output logic [IW-1:0] rd_addr,
  output logic [IW-1:0] wr_addr,
  output krt_rec_t      wr_data,
  input  krt_rec_t      rd_data,
  output logic          res_valid,
  output krt_result_t   res,
  input  logic          res_ready
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic [31:0]     key_r, key_nxt;
  krt_rec_t        rec_r, rec_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic            cmp_valid_r, cmp_valid_nxt;
  logic [IW-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic            cmp_last_r, cmp_last_nxt;
  logic            sh_valid_r, sh_valid_nxt;
  logic [IW-1:0]   sh_idx_r, sh_idx_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;

  logic            accept;
  logic            issue;
  logic            found;
  logic            missed;
  logic            full;
  logic [IW+PosW-1:0]   cmp_pos_ext;
  logic [CW+PosW-1:0]   cnt_pos_ext;
  logic [CW+CountW-1:0] cnt_out_ext;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  // Reads run one per cycle below the record count in both scan states.
  assign issue  = ((state_r == S_SEARCH) || (state_r == S_SHIFT)) && (scan_r < count_r);
  assign found  = (state_r == S_SEARCH) && cmp_valid_r && (rd_data.id == key_r);
  assign missed = (state_r == S_SEARCH) && !found &&
                  ((count_r == '0) || (cmp_valid_r && cmp_last_r));
  assign full   = (count_r == CW'(CAPACITY));

  assign cmp_pos_ext = {{PosW{1'b0}}, cmp_idx_r};
  assign cnt_pos_ext = {{PosW{1'b0}}, count_r};
  assign cnt_out_ext = {{CountW{1'b0}}, count_r};

  assign rd_addr       = scan_r[IW-1:0];

  assign res_valid       = (state_r == S_DONE);
  assign res.status      = status_r;
  assign res.position    = pos_r;
  assign res.entry_count = cnt_out_ext[CountW-1:0];

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    rec_nxt       = rec_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_last_nxt  = cmp_last_r;
    sh_valid_nxt  = 1'b0;
    sh_idx_nxt    = sh_idx_r;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    mem_ctl.rd_en = issue;
    mem_ctl.wr_en = 1'b0;
    wr_addr       = sh_idx_r;
    wr_data       = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt           = in_kind;
          key_nxt            = in_key;
          rec_nxt.id         = (in_kind == OP_UPDATE) ? in_new_key : in_key;
          rec_nxt.origin     = in_origin;
          rec_nxt.destination = in_destination;
          rec_nxt.weight     = in_weight_bits;
          scan_nxt           = '0;
          cmp_valid_nxt      = 1'b0;
          state_nxt          = S_SEARCH;
        end
      end

      S_SEARCH: begin
        cmp_valid_nxt = issue;
        cmp_idx_nxt   = scan_r[IW-1:0];
        cmp_last_nxt  = (scan_r == count_r - CW'(1));
        if (issue) begin
          scan_nxt = scan_r + CW'(1);
        end
        if (found || missed) begin
          cmp_valid_nxt = 1'b0;
          state_nxt     = S_DONE;
          status_nxt    = found ? ST_DONE : ST_MISSING;
          pos_nxt       = found ? cmp_pos_ext[PosW-1:0] : '0;
          case (kind_r)
            OP_INSERT: begin
              if (found) begin
                status_nxt = ST_DUP;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                status_nxt    = ST_DONE;
                pos_nxt       = cnt_pos_ext[PosW-1:0];
                mem_ctl.wr_en = 1'b1;
                wr_addr       = count_r[IW-1:0];
                wr_data       = rec_r;
                count_nxt     = count_r + CW'(1);
              end
            end
            OP_UPDATE: begin
              if (found) begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = cmp_idx_r;
                wr_data       = rec_r;
              end
            end
            OP_REMOVE: begin
              if (found) begin
                scan_nxt  = CW'(cmp_idx_r) + CW'(1);
                state_nxt = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Read entry j, write it to j-1 on the next cycle.
        mem_ctl.wr_en = sh_valid_r;
        sh_valid_nxt  = issue;
        if (issue) begin
          sh_idx_nxt = IW'(scan_r - CW'(1));
          scan_nxt   = scan_r + CW'(1);
        end
        if (!issue && !sh_valid_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      sh_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      sh_valid_r  <= sh_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    rec_r      <= rec_nxt;
    scan_r     <= scan_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    cmp_last_r <= cmp_last_nxt;
    sh_idx_r   <= sh_idx_nxt;
    status_r   <= status_nxt;
    pos_r      <= pos_nxt;
  end

endmodule

>>> rtl/krt_checker.sv
// Port-level checker for the keyed record table and its bind statement.
`timescale 1ns / 1ps
`include "keyed_record_table_defines.svh"

module krt_checker import krt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [1:0]          in_kind,
  input logic signed [31:0]  in_key,
  input logic signed [31:0]  in_new_key,
  input logic [15:0]         in_origin,
  input logic [15:0]         in_destination,
  input logic [31:0]         in_weight_bits,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          out_status,
  input logic [PosW-1:0]     out_position,
  input logic [CountW-1:0]   out_entry_count
);

  localparam int CapWrap = CAPACITY % (2 ** CountW);
  localparam logic [CountW-1:0] CapCount = CapWrap[CountW-1:0];

  // Whole input payload, so a stalled item can be checked for changes in one go.
  logic [129:0] in_payload;
  assign in_payload = {in_kind, in_key, in_new_key, in_origin, in_destination,
                       in_weight_bits};

  `KRT_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_payload), "stalled item changed")
  `KRT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_position) && $stable(out_entry_count), "stalled result changed")
  `KRT_ASSERT_NXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second item taken while one is at work")
  `KRT_ASSERT_IMP(a_full_count, out_valid && (out_status == ST_FULL), (out_entry_count == CapCount) && (out_position == '0), "full result with wrong count or position")
  `KRT_ASSERT_IMP(a_missing_pos, out_valid && (out_status == ST_MISSING), out_position == '0, "missing id with nonzero position")

endmodule

bind keyed_record_table krt_checker #(.CAPACITY(CAPACITY)) u_krt_checker (.*);
